### hdl/sdr_pkg.sv
// Shared types and codes for the simultaneous direction resolver.
package sdr_pkg;

   // Resolved direction codes
   localparam logic [2:0] DIR_NEUTRAL = 3'd0;
   localparam logic [2:0] DIR_UP      = 3'd1;
   localparam logic [2:0] DIR_RIGHT   = 3'd2;
   localparam logic [2:0] DIR_DOWN    = 3'd3;
   localparam logic [2:0] DIR_LEFT    = 3'd4;

   // direction_kind codes
   localparam logic KIND_TWO_WAY  = 1'b0;
   localparam logic KIND_FOUR_WAY = 1'b1;

   // resolve_policy codes
   localparam logic [1:0] POLICY_LAST    = 2'd0;
   localparam logic [1:0] POLICY_NEUTRAL = 2'd1;
   localparam logic [1:0] POLICY_FIRST   = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_KIND        = 2'd0;
   localparam logic [1:0] REG_POLICY      = 2'd1;
   localparam logic [1:0] REG_BUFFER_TIME = 2'd2;

   localparam int COMPONENTS = 4;
   localparam int ELAPSED_BITS = 16;

   typedef logic [2:0] dir_type;

   typedef struct packed {
      logic        direction_kind;
      logic [1:0]  resolve_policy;
      logic [15:0] buffer_time;
   } cfg_type;

   // True when the component named by dir is held in mask.
   function automatic logic dir_held(input dir_type dir, input logic [3:0] mask);
      logic held;
      case (dir)
         DIR_UP:    held = mask[0];
         DIR_RIGHT: held = mask[1];
         DIR_DOWN:  held = mask[2];
         DIR_LEFT:  held = mask[3];
         default:   held = 1'b0;
      endcase
      return held;
   endfunction

endpackage

### hdl/sdr_csr.sv
// Configuration register block with an APB-style write/read port.
module sdr_csr
   import sdr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready,
   output cfg_type       cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_KIND:        cfg_in.direction_kind = csr_pwdata[0];
            REG_POLICY:      cfg_in.resolve_policy = csr_pwdata[1:0];
            REG_BUFFER_TIME: cfg_in.buffer_time    = csr_pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction_kind <= KIND_FOUR_WAY;
         cfg_ff.resolve_policy <= POLICY_LAST;
         cfg_ff.buffer_time    <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KIND:        csr_prdata = {31'd0, cfg_ff.direction_kind};
         REG_POLICY:      csr_prdata = {30'd0, cfg_ff.resolve_policy};
         REG_BUFFER_TIME: csr_prdata = {16'd0, cfg_ff.buffer_time};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### hdl/sdr_core.sv
// Press stamping, resolve policies and tracking state for one item per cycle while advance is high.
module sdr_core
   import sdr_pkg::*;
#(
   parameter int STAMP_BITS = 32,
   parameter int TIME_BITS  = 16
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  cfg_type                 cfg,
   input  logic [3:0]              component_down,
   input  logic [ELAPSED_BITS-1:0] elapsed,
   output dir_type                 resolved,
   output dir_type                 prior,
   output logic                    changed
);

   localparam int CW = (TIME_BITS > ELAPSED_BITS) ? TIME_BITS : ELAPSED_BITS;

   logic [3:0]            held_ff, held_in;
   logic [STAMP_BITS-1:0] stamp_ff [COMPONENTS];
   logic [STAMP_BITS-1:0] stamp_in [COMPONENTS];
   logic [STAMP_BITS-1:0] next_ff, next_in;
   dir_type               pend_dir_ff, pend_dir_in;
   logic [TIME_BITS-1:0]  pend_time_ff, pend_time_in;
   dir_type               cur_ff;
   dir_type               res;

   logic [3:0]            mask;
   logic [3:0]            active;
   logic [2:0]            new_cnt;
   logic [STAMP_BITS-1:0] newest;
   logic [CW-1:0]         pend_ext, elapsed_ext, buf_ext, time_max;
   logic [TIME_BITS-1:0]  buf_sat;

   // choice helpers
   logic                  found;
   logic [STAMP_BITS-1:0] best;
   dir_type               last_pick, neutral_pick, first_pick, min_pick;
   logic [2:0]            held_cnt;

   always_comb begin
      active = (cfg.direction_kind == KIND_FOUR_WAY) ? 4'hF : 4'h3;
      mask   = component_down & active;

      // stamp new presses in index order
      new_cnt = 3'd0;
      for (int i = 0; i < COMPONENTS; i++) begin
         stamp_in[i] = stamp_ff[i];
         held_in[i]  = active[i] ? mask[i] : held_ff[i];
         if (mask[i] && !held_ff[i]) begin
            stamp_in[i] = next_ff + STAMP_BITS'(new_cnt);
            new_cnt     = new_cnt + 3'd1;
         end
      end
      next_in = next_ff + STAMP_BITS'(new_cnt);
      newest  = next_in - STAMP_BITS'(1);

      // last policy: largest stamp, earliest index on ties
      found     = 1'b0;
      best      = '0;
      last_pick = DIR_NEUTRAL;
      for (int i = 0; i < COMPONENTS; i++) begin
         if (mask[i] && (!found || stamp_in[i] > best)) begin
            found     = 1'b1;
            best      = stamp_in[i];
            last_pick = dir_type'(i + 1);
         end
      end

      // neutral policy: only a single held component wins
      held_cnt     = 3'd0;
      neutral_pick = DIR_NEUTRAL;
      for (int i = 0; i < COMPONENTS; i++) begin
         if (mask[i]) begin
            held_cnt = held_cnt + 3'd1;
            if (held_cnt == 3'd1) neutral_pick = dir_type'(i + 1);
         end
      end
      if (held_cnt != 3'd1) neutral_pick = DIR_NEUTRAL;

      // first policy: age the pending buffer, drop it when expired or released
      pend_dir_in  = pend_dir_ff;
      pend_time_in = pend_time_ff;
      pend_ext     = CW'(pend_time_ff);
      elapsed_ext  = CW'(elapsed);
      if (pend_dir_ff != DIR_NEUTRAL) begin
         pend_time_in = (pend_ext > elapsed_ext) ?
                        TIME_BITS'(pend_ext - elapsed_ext) : '0;
         if (pend_time_in == '0 || !dir_held(pend_dir_ff, mask)) begin
            pend_dir_in  = DIR_NEUTRAL;
            pend_time_in = '0;
         end
      end

      time_max = CW'({TIME_BITS{1'b1}});
      buf_ext  = CW'(cfg.buffer_time);
      buf_sat  = (buf_ext > time_max) ? {TIME_BITS{1'b1}} : TIME_BITS'(buf_ext);

      // buffer the newest press that competes with the kept direction
      for (int i = 0; i < COMPONENTS; i++) begin
         if (mask[i] && cur_ff != DIR_NEUTRAL && cur_ff != dir_type'(i + 1) &&
             stamp_in[i] == newest && cfg.buffer_time != 16'd0) begin
            pend_dir_in  = dir_type'(i + 1);
            pend_time_in = buf_sat;
         end
      end

      // fallback: smallest nonzero stamp
      best     = '0;
      min_pick = DIR_NEUTRAL;
      for (int i = 0; i < COMPONENTS; i++) begin
         if (mask[i] && (best == '0 || stamp_in[i] < best)) begin
            best     = stamp_in[i];
            min_pick = dir_type'(i + 1);
         end
      end

      if (cur_ff != DIR_NEUTRAL && dir_held(cur_ff, mask)) begin
         first_pick = cur_ff;
      end else if (pend_dir_in != DIR_NEUTRAL && dir_held(pend_dir_in, mask)) begin
         first_pick   = pend_dir_in;
         pend_dir_in  = DIR_NEUTRAL;
         pend_time_in = '0;
      end else begin
         first_pick = min_pick;
      end

      case (cfg.resolve_policy)
         POLICY_FIRST: res = first_pick;
         POLICY_NEUTRAL: begin
            res          = neutral_pick;
            pend_dir_in  = DIR_NEUTRAL;
            pend_time_in = '0;
         end
         default: begin
            res          = last_pick;
            pend_dir_in  = DIR_NEUTRAL;
            pend_time_in = '0;
         end
      endcase
   end

   assign resolved = res;
   assign prior    = cur_ff;
   assign changed  = (res != cur_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 4'd0;
         next_ff      <= STAMP_BITS'(1);
         pend_dir_ff  <= DIR_NEUTRAL;
         pend_time_ff <= '0;
         cur_ff       <= DIR_NEUTRAL;
         for (int i = 0; i < COMPONENTS; i++) stamp_ff[i] <= '0;
      end else if (advance) begin
         held_ff      <= held_in;
         next_ff      <= next_in;
         pend_dir_ff  <= pend_dir_in;
         pend_time_ff <= pend_time_in;
         cur_ff       <= res;
         for (int i = 0; i < COMPONENTS; i++) stamp_ff[i] <= stamp_in[i];
      end
   end

endmodule

### hdl/simultaneous_direction_resolver_top.sv
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while rsp_stall is low; sdr_core resolves combinationally.
// The input register, if empty, takes a new item while the result register waits on rsp_stall.
// Reset (synchronous, active high) clears both valid flags, the held bits, press stamps,
// the pending buffer and the kept direction; the stamp counter restarts at one.
// Configuration resets to four-way, last-input-wins, buffer time zero.
module simultaneous_direction_resolver_top
   import sdr_pkg::*;
#(
   parameter int STAMP_BITS = 32,
   parameter int TIME_BITS  = 16
)
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [3:0]   req_component_down,
   input  logic [15:0]  req_elapsed,
   // response channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_resolved,
   output logic [2:0]   rsp_prior,
   output logic         rsp_changed,
   // configuration port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type     cfg;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [3:0]  in_down_ff;
   logic [15:0] in_elapsed_ff;

   // result stage
   logic        out_valid_ff, out_valid_in;
   dir_type     out_resolved_ff, out_prior_ff;
   logic        out_changed_ff;

   dir_type     core_resolved, core_prior;
   logic        core_changed;

   logic        accept;
   logic        advance;

   sdr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Advance the held item into the result register whenever that register
   // is empty or being drained this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // Hold off a new item only while the input register cannot move on.
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   sdr_core #(
      .STAMP_BITS (STAMP_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .cfg            (cfg),
      .component_down (in_down_ff),
      .elapsed        (in_elapsed_ff),
      .resolved       (core_resolved),
      .prior          (core_prior),
      .changed        (core_changed)
   );

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: capture on accept, update result on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         in_down_ff    <= req_component_down;
         in_elapsed_ff <= req_elapsed;
      end
      if (advance) begin
         out_resolved_ff <= core_resolved;
         out_prior_ff    <= core_prior;
         out_changed_ff  <= core_changed;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_resolved = out_resolved_ff;
   assign rsp_prior    = out_prior_ff;
   assign rsp_changed  = out_changed_ff;

endmodule
